// ----- rtl/core/wef_pkg.sv -----
package wef_pkg;

	// Field and register widths
	localparam int TEMP_W   = 19;
	localparam int OFF_W    = 18;
	localparam int ALPHA_W  = 10;
	localparam int WEIGHT_W = 12;
	localparam int FILT_W   = 20;
	localparam int OUT_W    = 22;
	localparam int SIU_W    = 2;
	localparam int CFG_W    = 18;
	localparam int IDX_W    = 3;
	localparam int IN_BUS_W  = 40;
	localparam int OUT_BUS_W = 24;

	// Datapath widths
	localparam int PROD_W  = 31;
	localparam int RECIP_W = 30;
	localparam int WIDE_W  = PROD_W + RECIP_W;
	localparam int QUOT_W  = 22;

	localparam int SCALE = 1000;

	// floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT, exact for x below 2**31
	localparam logic [RECIP_W-1:0] RECIP = 30'd549755814;
	localparam int RECIP_SHIFT = 39;

	localparam int FILT_MAX = 524287;
	localparam int FILT_MIN = -524288;
	localparam int OUT_MAX  = 2097151;
	localparam int OUT_MIN  = -2097152;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SENSORS_IN_USE = 3'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA_A        = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_A       = 3'd2;
	localparam logic [IDX_W-1:0] REG_WEIGHT_A       = 3'd3;
	localparam logic [IDX_W-1:0] REG_ALPHA_B        = 3'd4;
	localparam logic [IDX_W-1:0] REG_OFFSET_B       = 3'd5;
	localparam logic [IDX_W-1:0] REG_WEIGHT_B       = 3'd6;

	typedef logic signed [OUT_W-1:0] term_t;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_MUL_A,
		STEP_MUL_B,
		STEP_DIV_M,
		STEP_DIV_F,
		STEP_MUL_W,
		STEP_DIV_T
	} step_t;

	typedef struct packed {
		logic  load;
		logic  use_lane;
		step_t step;
	} lane_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV_M1,
		ST_DIV_F,
		ST_MUL_W,
		ST_DIV_M2,
		ST_DIV_T,
		ST_SUM
	} state_t;

endpackage

// ----- rtl/core/wef_lane.sv -----
module wef_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wef_pkg::lane_ctrl_t                   ctrl,
	input  logic signed [wef_pkg::TEMP_W-1:0]     temp,
	input  logic signed [wef_pkg::OFF_W-1:0]      offset,
	input  logic        [wef_pkg::ALPHA_W-1:0]    alpha,
	input  logic signed [wef_pkg::WEIGHT_W-1:0]   weight,
	output wef_pkg::term_t                        term
);

	logic signed [wef_pkg::FILT_W-1:0]   filt_q;
	logic signed [wef_pkg::FILT_W-1:0]   diff_q;
	logic        [wef_pkg::ALPHA_W-1:0]  alpha_q;
	logic signed [wef_pkg::WEIGHT_W-1:0] weight_q;
	logic                                nohist_q;
	logic signed [wef_pkg::PROD_W-1:0]   p_q;
	logic                                neg_q;
	logic        [wef_pkg::WIDE_W-1:0]   r_q;
	wef_pkg::term_t                      term_q;

	logic signed [wef_pkg::FILT_W-1:0]   diff_w;
	logic        [wef_pkg::ALPHA_W-1:0]  alpha_w;
	logic        [wef_pkg::ALPHA_W-1:0]  comp_w;
	logic signed [wef_pkg::PROD_W-1:0]   mul_a_w;
	logic signed [wef_pkg::PROD_W-1:0]   mul_b_w;
	logic signed [wef_pkg::PROD_W-1:0]   mul_w_w;
	logic        [wef_pkg::PROD_W-1:0]   abs_w;
	logic        [wef_pkg::WIDE_W-1:0]   wide_w;
	logic        [wef_pkg::QUOT_W-1:0]   qmag_w;
	logic signed [wef_pkg::QUOT_W-1:0]   quot_w;
	logic signed [wef_pkg::QUOT_W-1:0]   cand_w;
	logic signed [wef_pkg::FILT_W-1:0]   filt_w;

	always_comb begin
		diff_w  = wef_pkg::FILT_W'(temp) - wef_pkg::FILT_W'(offset);
		alpha_w = (alpha > wef_pkg::ALPHA_W'(wef_pkg::SCALE)) ?
			wef_pkg::ALPHA_W'(wef_pkg::SCALE) : alpha;
		comp_w  = wef_pkg::ALPHA_W'(wef_pkg::SCALE) - alpha_q;
		mul_a_w = $signed({1'b0, alpha_q}) * diff_q;
		mul_b_w = $signed({1'b0, comp_w}) * filt_q;
		mul_w_w = weight_q * filt_q;
		abs_w   = p_q[wef_pkg::PROD_W-1] ? wef_pkg::PROD_W'(-p_q) : wef_pkg::PROD_W'(p_q);
		wide_w  = abs_w * wef_pkg::RECIP;
		qmag_w  = r_q[wef_pkg::RECIP_SHIFT +: wef_pkg::QUOT_W];
		quot_w  = neg_q ? -$signed(qmag_w) : $signed(qmag_w);
		// No history: load the offset-corrected reading as is
		cand_w  = nohist_q ? wef_pkg::QUOT_W'(diff_q) : quot_w;
		if (cand_w > wef_pkg::QUOT_W'(wef_pkg::FILT_MAX))
			filt_w = wef_pkg::FILT_W'(wef_pkg::FILT_MAX);
		else if (cand_w < wef_pkg::QUOT_W'(wef_pkg::FILT_MIN))
			filt_w = wef_pkg::FILT_W'(wef_pkg::FILT_MIN);
		else
			filt_w = cand_w[wef_pkg::FILT_W-1:0];
	end

	// Filter history; an unused lane keeps its value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (ctrl.step == wef_pkg::STEP_DIV_F && ctrl.use_lane) begin
			filt_q <= filt_w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			diff_q   <= diff_w;
			alpha_q  <= alpha_w;
			weight_q <= weight;
			nohist_q <= (filt_q == '0);
		end
		unique case (ctrl.step)
			wef_pkg::STEP_MUL_A: p_q <= mul_a_w;
			wef_pkg::STEP_MUL_B: p_q <= p_q + mul_b_w;
			wef_pkg::STEP_DIV_M: begin
				neg_q <= p_q[wef_pkg::PROD_W-1];
				r_q   <= wide_w;
			end
			wef_pkg::STEP_MUL_W: p_q <= mul_w_w;
			wef_pkg::STEP_DIV_T: term_q <= quot_w;
			default: ;
		endcase
	end

	assign term = term_q;

endmodule

// ----- rtl/core/wef_merge.sv -----
module wef_merge #(
	parameter int SENSORS = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  wef_pkg::term_t                   terms [SENSORS],
	input  logic [SENSORS-1:0]               use_mask,
	output logic                             free,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [wef_pkg::OUT_BUS_W-1:0]    m_tdata
);

	localparam int SUM_W = wef_pkg::OUT_W + $clog2(SENSORS) + 1;

	logic signed [SUM_W-1:0]         sum_w;
	logic signed [wef_pkg::OUT_W-1:0] sat_w;
	logic                            valid_q;
	logic signed [wef_pkg::OUT_W-1:0] out_q;

	always_comb begin
		sum_w = '0;
		for (int i = 0; i < SENSORS; i++) begin
			if (use_mask[i])
				sum_w = sum_w + SUM_W'(terms[i]);
		end
		if (sum_w > SUM_W'(wef_pkg::OUT_MAX))
			sat_w = wef_pkg::OUT_W'(wef_pkg::OUT_MAX);
		else if (sum_w < SUM_W'(wef_pkg::OUT_MIN))
			sat_w = wef_pkg::OUT_W'(wef_pkg::OUT_MIN);
		else
			sat_w = sum_w[wef_pkg::OUT_W-1:0];
	end

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (go) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			out_q <= sat_w;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(wef_pkg::OUT_BUS_W - wef_pkg::OUT_W){1'b0}}, out_q};

endmodule

// ----- rtl/core/weighted_ema_sensor_fusion.sv -----
// Weighted EMA fusion of up to two temperature sensors. Each input transfer
// carries one millidegree reading per sensor; each lane subtracts its offset,
// loads the result directly when its filtered value is zero (after reset, or
// when the filter lands on zero) and otherwise updates it as
// (alpha*diff + (1000-alpha)*old)/1000, saturated to 20 bits. The output
// transfer carries the sum of weight*filtered/1000 over the sensors in use,
// saturated to 22 bits; all divisions truncate toward zero. The block takes
// a new item only after its lanes are through with the last one: each lane
// runs seven steps in turn (a multiply and a multiply-accumulate for the
// filter, a reciprocal multiply and a sign/saturate step for its division by
// 1000, the weight multiply, and a reciprocal multiply and a sign step for
// the division of the term by 1000), then the merge stage adds the lane
// terms into the output register, and the sequencer returns to idle to take
// the next input. Input is accepted while a finished result still waits in
// that register; the sequencer then holds in SUM until the register is free.
// Write configuration only while the block is idle.
module weighted_ema_sensor_fusion #(
	parameter int SENSORS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [wef_pkg::IDX_W-1:0]         cfg_index,
	input  logic [wef_pkg::CFG_W-1:0]         cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wef_pkg::IN_BUS_W-1:0]      s_tdata,  // sensor_temp_a, sensor_temp_b
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wef_pkg::OUT_BUS_W-1:0]     m_tdata   // combined_temp
);

	wef_pkg::state_t state_q, state_d;

	logic [wef_pkg::SIU_W-1:0]           sensors_in_use_q;
	logic [wef_pkg::ALPHA_W-1:0]         alpha_q  [2];
	logic signed [wef_pkg::OFF_W-1:0]    offset_q [2];
	logic signed [wef_pkg::WEIGHT_W-1:0] weight_q [2];

	logic signed [wef_pkg::TEMP_W-1:0]   temp_w [2];
	logic [SENSORS-1:0]                  use_mask;
	wef_pkg::step_t                      step_w;
	wef_pkg::term_t                      terms [SENSORS];
	logic                                accept;
	logic                                go;
	logic                                out_free;

	assign temp_w[0] = $signed(s_tdata[wef_pkg::TEMP_W-1:0]);
	assign temp_w[1] = $signed(s_tdata[2*wef_pkg::TEMP_W-1:wef_pkg::TEMP_W]);

	// Register file: hold values until rewritten, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensors_in_use_q <= 2'd2;
			alpha_q[0]       <= 10'd1000;
			offset_q[0]      <= '0;
			weight_q[0]      <= 12'sd1000;
			alpha_q[1]       <= 10'd1000;
			offset_q[1]      <= '0;
			weight_q[1]      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wef_pkg::REG_SENSORS_IN_USE: sensors_in_use_q <= cfg_wdata[wef_pkg::SIU_W-1:0];
				wef_pkg::REG_ALPHA_A:  alpha_q[0]  <= cfg_wdata[wef_pkg::ALPHA_W-1:0];
				wef_pkg::REG_OFFSET_A: offset_q[0] <= cfg_wdata[wef_pkg::OFF_W-1:0];
				wef_pkg::REG_WEIGHT_A: weight_q[0] <= cfg_wdata[wef_pkg::WEIGHT_W-1:0];
				wef_pkg::REG_ALPHA_B:  alpha_q[1]  <= cfg_wdata[wef_pkg::ALPHA_W-1:0];
				wef_pkg::REG_OFFSET_B: offset_q[1] <= cfg_wdata[wef_pkg::OFF_W-1:0];
				wef_pkg::REG_WEIGHT_B: weight_q[1] <= cfg_wdata[wef_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Lane i is in use when the count (zero taken as one, capped at SENSORS)
	// exceeds i; the first lane is always in use.
	always_comb begin
		for (int i = 0; i < SENSORS; i++)
			use_mask[i] = (i == 0) || (sensors_in_use_q > wef_pkg::SIU_W'(i));
	end

	assign s_tready = (state_q == wef_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Sequencer: advance the lanes one step a cycle, wait in SUM while the
	// output register still holds an untaken result.
	always_comb begin
		state_d = state_q;
		step_w  = wef_pkg::STEP_NONE;
		go      = 1'b0;
		unique case (state_q)
			wef_pkg::ST_IDLE:   if (accept) state_d = wef_pkg::ST_MUL_A;
			wef_pkg::ST_MUL_A: begin
				step_w  = wef_pkg::STEP_MUL_A;
				state_d = wef_pkg::ST_MUL_B;
			end
			wef_pkg::ST_MUL_B: begin
				step_w  = wef_pkg::STEP_MUL_B;
				state_d = wef_pkg::ST_DIV_M1;
			end
			wef_pkg::ST_DIV_M1: begin
				step_w  = wef_pkg::STEP_DIV_M;
				state_d = wef_pkg::ST_DIV_F;
			end
			wef_pkg::ST_DIV_F: begin
				step_w  = wef_pkg::STEP_DIV_F;
				state_d = wef_pkg::ST_MUL_W;
			end
			wef_pkg::ST_MUL_W: begin
				step_w  = wef_pkg::STEP_MUL_W;
				state_d = wef_pkg::ST_DIV_M2;
			end
			wef_pkg::ST_DIV_M2: begin
				step_w  = wef_pkg::STEP_DIV_M;
				state_d = wef_pkg::ST_DIV_T;
			end
			wef_pkg::ST_DIV_T: begin
				step_w  = wef_pkg::STEP_DIV_T;
				state_d = wef_pkg::ST_SUM;
			end
			wef_pkg::ST_SUM: begin
				if (out_free) begin
					go      = 1'b1;
					state_d = wef_pkg::ST_IDLE;
				end
			end
			default: state_d = wef_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wef_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	for (genvar i = 0; i < SENSORS; i++) begin : g_lane
		wef_pkg::lane_ctrl_t ctrl;

		assign ctrl.load     = accept;
		assign ctrl.use_lane = use_mask[i];
		assign ctrl.step     = step_w;

		wef_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.temp   (temp_w[i]),
			.offset (offset_q[i]),
			.alpha  (alpha_q[i]),
			.weight (weight_q[i]),
			.term   (terms[i])
		);
	end

	wef_merge #(
		.SENSORS (SENSORS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.terms    (terms),
		.use_mask (use_mask),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	// A result is visible once the sequence after its input transfer has run,
	// freshly loaded or an older one still waiting in the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##9 m_tvalid)
		else $error("result not presented eight cycles after input transfer");

	// A blocked output register keeps the sequencer waiting in SUM
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wef_pkg::ST_SUM && !out_free) |=> (state_q == wef_pkg::ST_SUM))
		else $error("sequencer left SUM while output register was full");

	// A new result only appears out of the SUM step
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == wef_pkg::ST_SUM))
		else $error("output valid raised outside the SUM step");
`endif

endmodule

// ----- dv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wef_pkg::*;

	localparam int SENSORS        = 2;
	localparam int MAX_GAP        = 14;      // longest idle draw on either side
	localparam int HOLD_CYCLES    = 300;     // long output hold to back up the block
	localparam int SETTLE_CYCLES  = 12;      // wait after a drain, past the block latency
	localparam int WATCHDOG_LIMIT = 2000;    // quiet cycles before giving up
	localparam int TOTAL_POLLS    = 1350;
	localparam int REPORT_LIMIT   = 25;

	// index past the last register; writes to it must change nothing
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic signed [TEMP_W-1:0]   TEMP_LOW    = -262144;
	localparam logic signed [TEMP_W-1:0]   TEMP_HIGH   = 262143;
	localparam logic signed [OFF_W-1:0]    OFF_LOW     = -131072;
	localparam logic signed [OFF_W-1:0]    OFF_HIGH    = 131071;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_LOW  = -2048;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_HIGH = 2047;
	localparam logic [ALPHA_W-1:0]         ALPHA_TOP   = 10'd1023;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_BUS_W-1:0]  s_tdata   = '0;   // sensor_temp_a, sensor_temp_b
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_BUS_W-1:0] m_tdata;          // combined_temp

	// Shadow copy of the register file and the per-sensor filter state
	logic [SIU_W-1:0]           cfg_sensors;
	logic [ALPHA_W-1:0]         cfg_alpha  [SENSORS];
	logic signed [OFF_W-1:0]    cfg_offset [SENSORS];
	logic signed [WEIGHT_W-1:0] cfg_weight [SENSORS];
	logic signed [FILT_W-1:0]   filt_state [SENSORS];

	// Combined temperatures still owed by the block, oldest first
	term_t pending_combined [$];

	int  mismatch_count = 0;
	int  polls_sent     = 0;
	int  results_seen   = 0;
	int  reg_writes     = 0;
	int  input_stalls   = 0;
	int  quiet_cycles   = 0;
	bit  src_idle_on    = 1'b0;
	bit  sink_idle_on   = 1'b0;
	bit  hold_request   = 1'b0;
	int  last_temp [SENSORS];

	always #1 clk = ~clk;

	weighted_ema_sensor_fusion #(
		.SENSORS(SENSORS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------
	// Fusion predictor: advance the filter state for one poll and return
	// the combined temperature the block owes for it.
	// ------------------------------------------------------------------
	function automatic term_t fuse_poll(logic signed [TEMP_W-1:0] temp_a,
					    logic signed [TEMP_W-1:0] temp_b);
		longint lanes, temp, diff, alpha, blend, total;
		int i;
		// a count of zero still uses the first sensor; clip to the lanes built
		lanes = (cfg_sensors == 0) ? 1 : longint'(cfg_sensors);
		if (lanes > SENSORS)
			lanes = SENSORS;
		total = 0;
		for (i = 0; i < lanes; i++) begin
			temp  = (i == 0) ? temp_a : temp_b;
			diff  = temp - longint'(cfg_offset[i]);
			alpha = cfg_alpha[i];
			if (alpha > SCALE)
				alpha = SCALE;
			// zero means no history: load the corrected reading as is
			if (filt_state[i] == 0)
				blend = diff;
			else
				blend = (alpha * diff + (SCALE - alpha) * longint'(filt_state[i]))
					/ SCALE;
			if (blend > FILT_MAX)
				blend = FILT_MAX;
			if (blend < FILT_MIN)
				blend = FILT_MIN;
			filt_state[i] = blend[FILT_W-1:0];
			total += (longint'(cfg_weight[i]) * blend) / SCALE;
		end
		if (total > OUT_MAX)
			total = OUT_MAX;
		if (total < OUT_MIN)
			total = OUT_MIN;
		return total[OUT_W-1:0];
	endfunction

	task automatic reset_shadow();
		int i;
		cfg_sensors = 2'd2;
		for (i = 0; i < SENSORS; i++) begin
			cfg_alpha[i]  = 10'd1000;
			cfg_offset[i] = '0;
			cfg_weight[i] = '0;
			filt_state[i] = '0;
			last_temp[i]  = 25000;
		end
		cfg_weight[0] = 12'sd1000;
	endtask

	// ------------------------------------------------------------------
	// Register write: one cycle with the enable high, then the enable is held low
	// before returning, so back-to-back writes never re-raise it in the same step.
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		cfg_index <= index;
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		reg_writes++;
		case (index)
			REG_SENSORS_IN_USE: cfg_sensors   = value[SIU_W-1:0];
			REG_ALPHA_A:        cfg_alpha[0]  = value[ALPHA_W-1:0];
			REG_OFFSET_A:       cfg_offset[0] = value[OFF_W-1:0];
			REG_WEIGHT_A:       cfg_weight[0] = value[WEIGHT_W-1:0];
			REG_ALPHA_B:        cfg_alpha[1]  = value[ALPHA_W-1:0];
			REG_OFFSET_B:       cfg_offset[1] = value[OFF_W-1:0];
			REG_WEIGHT_B:       cfg_weight[1] = value[WEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Send one poll. Valid stays high across back-to-back polls; this task
	// drops it only when this poll draws an idle gap.
	// ------------------------------------------------------------------
	task automatic send_poll(input logic signed [TEMP_W-1:0] temp_a,
				 input logic signed [TEMP_W-1:0] temp_b);
		int gap;
		gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {{(IN_BUS_W - 2 * TEMP_W){1'b0}}, temp_b, temp_a};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_combined.push_back(fuse_poll(temp_a, temp_b));
		polls_sent++;
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle.
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (pending_combined.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input term_t got, input term_t want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("MISMATCH %s: got %0d expected %0d (result %0d)",
				 what, got, want, results_seen);
	endtask

	// Keep bits the register ignores random so the block must mask them.
	function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] value, int width);
		logic [CFG_W-1:0] mask;
		mask = (18'h1 << width) - 18'h1;
		return (CFG_W'($urandom) & ~mask) | (value & mask);
	endfunction

	// Pick a reading: mostly a slow drift so the filter builds history,
	// with full-range noise, extremes and offset-cancelling readings mixed in.
	function automatic logic signed [TEMP_W-1:0] pick_temp(int lane);
		int v;
		case ($urandom_range(0, 9))
			0: return TEMP_W'(cfg_offset[lane]);
			1: begin
				case ($urandom_range(0, 3))
					0: return TEMP_LOW;
					1: return TEMP_HIGH;
					2: return '1;
					default: return '0;
				endcase
			end
			2, 3: return TEMP_W'($urandom);
			default: begin
				v = last_temp[lane] + int'($urandom_range(0, 4000)) - 2000;
				if (v > 200000)
					v = 200000;
				if (v < -100000)
					v = -100000;
				last_temp[lane] = v;
				return v[TEMP_W-1:0];
			end
		endcase
	endfunction

	task automatic randomize_regs();
		logic [ALPHA_W-1:0] alpha;
		logic [CFG_W-1:0] offset;
		logic [WEIGHT_W-1:0] weight;
		int lane;
		write_reg(REG_SENSORS_IN_USE, CFG_W'($urandom));
		for (lane = 0; lane < SENSORS; lane++) begin
			case ($urandom_range(0, 5))
				0: alpha = '0;
				1: alpha = 10'd1000;
				2: alpha = ALPHA_TOP;
				default: alpha = ALPHA_W'($urandom_range(0, 1023));
			endcase
			case ($urandom_range(0, 5))
				0: offset = CFG_W'(OFF_LOW);
				1: offset = CFG_W'(OFF_HIGH);
				2: offset = '0;
				default: offset = CFG_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: weight = WEIGHT_LOW;
				1: weight = WEIGHT_HIGH;
				2: weight = 12'd1000;
				default: weight = WEIGHT_W'($urandom);
			endcase
			write_reg((lane == 0) ? REG_ALPHA_A : REG_ALPHA_B,
				  with_junk(CFG_W'(alpha), ALPHA_W));
			write_reg((lane == 0) ? REG_OFFSET_A : REG_OFFSET_B, offset);
			write_reg((lane == 0) ? REG_WEIGHT_A : REG_WEIGHT_B,
				  with_junk(CFG_W'(weight), WEIGHT_W));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values: both sensors, no smoothing, only sensor a weighted.
	task automatic test_reset_defaults();
		send_poll(25000, 30000);
		send_poll(TEMP_LOW, TEMP_HIGH);
		send_poll(TEMP_HIGH, TEMP_LOW);
		send_poll(-1, 1);
		send_poll(-100000, 200000);
		send_poll(200000, -100000);
	endtask

	// Register extremes: sensor count zero and above the lane count, alpha
	// above full scale and at zero, offset and weight at both ends.
	task automatic test_config_extremes();
		drain_outputs();
		write_reg(REG_SENSORS_IN_USE, '0);
		write_reg(REG_ALPHA_A, CFG_W'(ALPHA_TOP));
		write_reg(REG_OFFSET_A, CFG_W'(OFF_LOW));
		write_reg(REG_WEIGHT_A, CFG_W'(WEIGHT_HIGH));
		write_reg(REG_UNUSED, '1);
		send_poll(TEMP_HIGH, TEMP_LOW);
		send_poll(TEMP_LOW, TEMP_HIGH);
		send_poll(0, 0);

		drain_outputs();
		write_reg(REG_SENSORS_IN_USE, CFG_W'(3));
		write_reg(REG_ALPHA_A, '0);
		write_reg(REG_OFFSET_A, CFG_W'(OFF_HIGH));
		write_reg(REG_WEIGHT_A, CFG_W'(WEIGHT_LOW));
		write_reg(REG_ALPHA_B, CFG_W'(ALPHA_TOP));
		write_reg(REG_OFFSET_B, CFG_W'(OFF_LOW));
		write_reg(REG_WEIGHT_B, CFG_W'(WEIGHT_LOW));
		send_poll(TEMP_LOW, TEMP_HIGH);
		send_poll(TEMP_HIGH, TEMP_LOW);
		send_poll(1, -1);

		// one sensor: lane b must keep its state untouched
		drain_outputs();
		write_reg(REG_SENSORS_IN_USE, CFG_W'(1));
		write_reg(REG_ALPHA_A, CFG_W'(500));
		write_reg(REG_OFFSET_A, '0);
		write_reg(REG_WEIGHT_A, '0);
		send_poll(-7, TEMP_HIGH);
		send_poll(123456, TEMP_LOW);
		send_poll(-654, 99);
	endtask

	// Filter landing on zero counts as no history, with and without smoothing,
	// and negative quotients truncate toward zero.
	task automatic test_filter_zero();
		drain_outputs();
		write_reg(REG_SENSORS_IN_USE, CFG_W'(2));
		write_reg(REG_ALPHA_A, CFG_W'(1000));
		write_reg(REG_WEIGHT_A, CFG_W'(1000));
		write_reg(REG_OFFSET_B, '0);
		write_reg(REG_ALPHA_B, CFG_W'(500));
		write_reg(REG_WEIGHT_B, CFG_W'(-999));
		send_poll(5000, 0);
		send_poll(0, 0);
		send_poll(777, 1);
		send_poll(0, -1);
		send_poll(-3, -3);
		send_poll(-3, 0);
		send_poll(1, 5);
	endtask

	// Hold the output off for a long stretch while polls keep coming, so the
	// block fills and stalls its input.
	task automatic test_output_stall();
		int k;
		drain_outputs();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		hold_request = 1'b1;
		for (k = 0; k < 24; k++)
			send_poll(pick_temp(0), pick_temp(1));
		drain_outputs();
	endtask

	// Random register phases with drifting readings and random idling.
	task automatic test_random_polls();
		int phase_len, k;
		while (polls_sent < TOTAL_POLLS) begin
			drain_outputs();
			randomize_regs();
			src_idle_on  = ($urandom_range(0, 2) != 0);
			sink_idle_on = ($urandom_range(0, 2) != 0);
			phase_len = $urandom_range(30, 90);
			for (k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 15) == 0)
					src_idle_on = ~src_idle_on;
				if ($urandom_range(0, 15) == 0)
					sink_idle_on = ~sink_idle_on;
				// now and then pause until the block has caught up
				if ($urandom_range(0, 49) == 0)
					drain_outputs();
				send_poll(pick_temp(0), pick_temp(1));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		reset_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_filter_zero();
		test_output_stall();
		test_random_polls();
		drain_outputs();
		$display("run: %0d polls, %0d results, %0d register writes, %0d input stall cycles",
			 polls_sent, results_seen, reg_writes, input_stalls);
		$display("run: sensor counts 0..3, alpha past full scale, offset and weight limits, "
			 , "filter reload on zero, long output hold, random idling");
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Result sink: draw a stall per transfer, honor a long hold on request.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Check each output transfer against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_combined.size() == 0)
				report_mismatch("combined_temp with none pending",
						term_t'(m_tdata[OUT_W-1:0]), '0);
			else if (m_tdata[OUT_W-1:0] !== pending_combined[0])
				report_mismatch("combined_temp", term_t'(m_tdata[OUT_W-1:0]),
						pending_combined.pop_front());
			else
				void'(pending_combined.pop_front());
			results_seen++;
		end
	end

	// Watchdog: give up after a long stretch with no transfer of any kind.
	always @(posedge clk) begin
		if (s_tvalid && !s_tready)
			input_stalls++;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results pending",
					 quiet_cycles, pending_combined.size());
				$display("tb failed");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/core/wef_pkg.sv
rtl/core/wef_lane.sv
rtl/core/wef_merge.sv
rtl/core/weighted_ema_sensor_fusion.sv
dv/tb.sv
